>>> sv/sejs_pkg.sv
package sejs_pkg;

   localparam int unsigned ADDR_W  = 16;
   localparam int unsigned SIZE_W  = 17;
   localparam int unsigned BLOCK_W = 7;
   localparam int unsigned PAGE_W  = 9;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 17;
   localparam int unsigned DIV_STEPS  = 17;

   localparam logic [2:0] OP_READ    = 3'd0;
   localparam logic [2:0] OP_WRITE   = 3'd1;
   localparam logic [2:0] OP_COMPARE = 3'd2;
   localparam logic [2:0] OP_POLL    = 3'd3;
   localparam logic [2:0] OP_CANCEL  = 3'd4;

   localparam logic [2:0] CSR_FAST_MODE    = 3'd0;
   localparam logic [2:0] CSR_FAST_READ    = 3'd1;
   localparam logic [2:0] CSR_NORMAL_READ  = 3'd2;
   localparam logic [2:0] CSR_FAST_WRITE   = 3'd3;
   localparam logic [2:0] CSR_NORMAL_WRITE = 3'd4;
   localparam logic [2:0] CSR_PAGE_BYTES   = 3'd5;
   localparam logic [2:0] CSR_DEVICE_BYTES = 3'd6;
   localparam logic [2:0] CSR_BASE_OFFSET  = 3'd7;

   localparam logic [1:0] SPI_PENDING = 2'd0;
   localparam logic [1:0] SPI_OK      = 2'd1;

   localparam logic [1:0] CMD_NONE   = 2'd0;
   localparam logic [1:0] CMD_READ   = 2'd1;
   localparam logic [1:0] CMD_WRITE  = 2'd2;
   localparam logic [1:0] CMD_STATUS = 2'd3;

   localparam logic [1:0] RES_OK        = 2'd0;
   localparam logic [1:0] RES_PENDING   = 2'd1;
   localparam logic [1:0] RES_FAILED    = 2'd2;
   localparam logic [1:0] RES_CANCELLED = 2'd3;

   localparam logic [1:0] KIND_NONE    = 2'd0;
   localparam logic [1:0] KIND_READ    = 2'd1;
   localparam logic [1:0] KIND_WRITE   = 2'd2;
   localparam logic [1:0] KIND_COMPARE = 2'd3;

   localparam logic [1:0] PH_MAIN   = 2'd0;
   localparam logic [1:0] PH_STATUS = 2'd1;
   localparam logic [1:0] PH_CHECK  = 2'd2;

   localparam logic [7:0] STATUS_MASK = 8'hff;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [15:0] address;
      logic [16:0] length;
      logic [1:0]  spi_result;
      logic        spi_accepts;
      logic [7:0]  status_byte;
      logic        compare_equal;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic [1:0]  spi_command;
      logic [15:0] spi_address;
      logic [6:0]  chunk_bytes;
      logic [16:0] buffer_offset;
      logic        compare_check;
      logic        driver_busy;
      logic [1:0]  job_result;
      logic        job_end;
      logic        job_error;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic div_last;
   } sts_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_EXEC
   } state_type;

endpackage

>>> sv/sejs_ctrl.sv
module sejs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  sejs_pkg::sts_type sts,
   output sejs_pkg::cmd_type cmd
);
   import sejs_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_DIV;
         ST_DIV:  if (sts.div_last) state_in = ST_EXEC;
         ST_EXEC: if (slot_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_DIV:  cmd.div_step = 1'b1;
         ST_EXEC: cmd.commit = slot_free;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (cmd.commit) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> sv/sejs_dp.sv
module sejs_dp #(
   parameter int unsigned COMPARE_BLOCK = 64,
   parameter int unsigned ADDR_BITS     = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sejs_pkg::req_type                    req_payload,
   output sejs_pkg::rsp_type                    rsp_payload,
   input  logic                                 csr_write,
   input  logic [sejs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sejs_pkg::CSR_DATA_W-1:0]      csr_data,
   input  sejs_pkg::cmd_type                    cmd,
   output sejs_pkg::sts_type                    sts
);
   import sejs_pkg::*;

   localparam int unsigned BLK_W = $clog2(COMPARE_BLOCK + 1);
   localparam logic [31:0] ADDR_MASK32 = (32'd1 << ADDR_BITS) - 32'd1;
   localparam logic [SIZE_W-1:0] ADDR_MASK = ADDR_MASK32[SIZE_W-1:0];
   localparam logic [SIZE_W-1:0] CB17 = SIZE_W'(COMPARE_BLOCK);

   // configuration
   logic                fast_mode_ff;
   logic [BLOCK_W-1:0]  fast_read_ff, normal_read_ff, fast_write_ff, normal_write_ff;
   logic [PAGE_W-1:0]   page_ff;
   logic [SIZE_W-1:0]   device_ff;
   logic [ADDR_W-1:0]   base_ff;

   // job state
   logic                busy_ff, busy_in, first_ff, first_in;
   logic [1:0]          result_ff, result_in, kind_ff, kind_in, phase_ff, phase_in;
   logic [SIZE_W-1:0]   naddr_ff, naddr_in, left_ff, left_in, done_ff, done_in;
   logic [BLOCK_W-1:0]  limit_ff, limit_in;
   logic [BLK_W-1:0]    bleft_ff, bleft_in, bbytes_ff, bbytes_in;

   // request and remainder divider
   req_type             req_ff;
   logic [SIZE_W-1:0]   quot_ff;
   logic [PAGE_W-1:0]   rem_ff;
   logic [4:0]          cnt_ff;
   logic [PAGE_W:0]     trial;
   rsp_type             rsp_ff, rsp_in;

   assign trial = {rem_ff, quot_ff[SIZE_W-1]};
   assign sts.div_last = (cnt_ff == 5'(DIV_STEPS - 1));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff  <= req_payload;
         quot_ff <= naddr_ff;
         rem_ff  <= '0;
         cnt_ff  <= '0;
      end else if (cmd.div_step) begin
         quot_ff <= {quot_ff[SIZE_W-2:0], 1'b0};
         cnt_ff  <= cnt_ff + 5'd1;
         if (trial >= {1'b0, page_ff}) rem_ff <= PAGE_W'(trial - {1'b0, page_ff});
         else rem_ff <= trial[PAGE_W-1:0];
      end
   end

   function automatic logic [BLOCK_W-1:0] clamp_block(input logic [BLOCK_W-1:0] v);
      if (v == '0) return BLOCK_W'(1);
      if (v > BLOCK_W'(64)) return BLOCK_W'(64);
      return v;
   endfunction

   always_comb begin
      logic [SIZE_W-1:0]  cur_left;
      logic [SIZE_W-1:0]  addr17, len17;
      logic [BLOCK_W-1:0] blk, c;
      logic [PAGE_W:0]    room;
      logic               go, done_sub, fail, acc;
      logic [1:0]         ph;

      busy_in = busy_ff; first_in = first_ff; result_in = result_ff;
      kind_in = kind_ff; phase_in = phase_ff; naddr_in = naddr_ff;
      left_in = left_ff; done_in = done_ff; limit_in = limit_ff;
      bleft_in = bleft_ff; bbytes_in = bbytes_ff;
      rsp_in = '0;
      addr17 = {1'b0, req_ff.address};
      len17 = req_ff.length;
      acc = req_ff.spi_accepts;
      cur_left = (kind_ff == KIND_COMPARE) ? SIZE_W'(bleft_ff) : left_ff;
      go = 1'b0; done_sub = 1'b0; fail = 1'b0;
      ph = phase_ff; c = '0; room = '0; blk = '0;

      case (req_ff.opcode)
         OP_READ, OP_WRITE, OP_COMPARE: begin
            if (!busy_ff && addr17 < device_ff && len17 <= device_ff - addr17) begin
               if (req_ff.opcode == OP_WRITE)
                  blk = fast_mode_ff ? fast_write_ff : normal_write_ff;
               else
                  blk = fast_mode_ff ? fast_read_ff : normal_read_ff;
               busy_in = 1'b1;
               result_in = RES_PENDING;
               kind_in = (req_ff.opcode == OP_READ) ? KIND_READ :
                         (req_ff.opcode == OP_WRITE) ? KIND_WRITE : KIND_COMPARE;
               limit_in = clamp_block(blk);
               first_in = 1'b1;
               phase_in = PH_MAIN;
               naddr_in = SIZE_W'(addr17 + {1'b0, base_ff});
               left_in = len17;
               done_in = '0;
               bbytes_in = (len17 < CB17) ? len17[BLK_W-1:0] : BLK_W'(COMPARE_BLOCK);
               bleft_in = bbytes_in;
               rsp_in.accepted = 1'b1;
            end
         end
         OP_POLL: begin
            if (result_ff == RES_PENDING && busy_ff && kind_ff != KIND_NONE) begin
               if (first_ff) begin
                  first_in = 1'b0;
                  go = 1'b1;
               end else if (req_ff.spi_result == SPI_PENDING) begin
                  go = 1'b0;
               end else if (req_ff.spi_result != SPI_OK) begin
                  fail = 1'b1;
               end else begin
                  go = 1'b1;
               end
               if (go) begin
                  if (ph == PH_CHECK)
                     ph = ((req_ff.status_byte & STATUS_MASK) & 8'h01) != 8'h00 ?
                          PH_STATUS : PH_MAIN;
                  if (ph == PH_STATUS) begin
                     phase_in = PH_STATUS;
                     if (acc) begin
                        rsp_in.spi_command = CMD_STATUS;
                        phase_in = PH_CHECK;
                     end
                  end else begin
                     phase_in = PH_MAIN;
                     if (cur_left == '0) begin
                        done_sub = 1'b1;
                     end else begin
                        c = (cur_left < SIZE_W'(limit_ff)) ? cur_left[BLOCK_W-1:0] : limit_ff;
                        if (kind_ff == KIND_WRITE && page_ff != '0) begin
                           room = {1'b0, page_ff} - {1'b0, rem_ff};
                           if ({3'b0, c} > room) c = room[BLOCK_W-1:0];
                        end
                        if (acc) begin
                           rsp_in.spi_command = (kind_ff == KIND_WRITE) ? CMD_WRITE : CMD_READ;
                           rsp_in.spi_address = ADDR_W'(naddr_ff & ADDR_MASK);
                           rsp_in.chunk_bytes = c;
                           rsp_in.buffer_offset = done_ff;
                           naddr_in = SIZE_W'(naddr_ff + SIZE_W'(c));
                           done_in = SIZE_W'(done_ff + SIZE_W'(c));
                           if (kind_ff == KIND_COMPARE) bleft_in = BLK_W'(cur_left - SIZE_W'(c));
                           else left_in = SIZE_W'(cur_left - SIZE_W'(c));
                           phase_in = PH_STATUS;
                        end
                     end
                  end
               end
               if (done_sub) begin
                  if (kind_ff != KIND_COMPARE) begin
                     rsp_in.job_end = 1'b1;
                     result_in = RES_OK;
                     busy_in = 1'b0; kind_in = KIND_NONE; phase_in = PH_MAIN; first_in = 1'b0;
                  end else begin
                     if (bbytes_ff != '0) rsp_in.compare_check = 1'b1;
                     if (bbytes_ff != '0 && !req_ff.compare_equal) begin
                        fail = 1'b1;
                     end else begin
                        left_in = SIZE_W'(left_ff - SIZE_W'(bbytes_ff));
                        if (left_in == '0) begin
                           rsp_in.job_end = 1'b1;
                           result_in = RES_OK;
                           busy_in = 1'b0; kind_in = KIND_NONE;
                           phase_in = PH_MAIN; first_in = 1'b0;
                        end else begin
                           bbytes_in = (left_in < CB17) ? left_in[BLK_W-1:0] :
                                       BLK_W'(COMPARE_BLOCK);
                           bleft_in = bbytes_in;
                           first_in = 1'b1;
                           phase_in = PH_MAIN;
                        end
                     end
                  end
               end
               if (fail) begin
                  rsp_in.job_error = 1'b1;
                  result_in = RES_FAILED;
                  busy_in = 1'b0; kind_in = KIND_NONE; phase_in = PH_MAIN; first_in = 1'b0;
               end
            end
         end
         OP_CANCEL: begin
            rsp_in.job_error = 1'b1;
            result_in = (result_ff == RES_PENDING) ? RES_CANCELLED : result_ff;
            busy_in = 1'b0; kind_in = KIND_NONE; phase_in = PH_MAIN; first_in = 1'b0;
         end
         default: ;
      endcase
      rsp_in.driver_busy = busy_in;
      rsp_in.job_result = result_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fast_mode_ff <= 1'b0;
         fast_read_ff <= 7'd64; normal_read_ff <= 7'd32;
         fast_write_ff <= 7'd32; normal_write_ff <= 7'd16;
         page_ff <= 9'd16; device_ff <= 17'd2048; base_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_FAST_MODE:    fast_mode_ff <= csr_data[0];
            CSR_FAST_READ:    fast_read_ff <= csr_data[BLOCK_W-1:0];
            CSR_NORMAL_READ:  normal_read_ff <= csr_data[BLOCK_W-1:0];
            CSR_FAST_WRITE:   fast_write_ff <= csr_data[BLOCK_W-1:0];
            CSR_NORMAL_WRITE: normal_write_ff <= csr_data[BLOCK_W-1:0];
            CSR_PAGE_BYTES:   page_ff <= csr_data[PAGE_W-1:0];
            CSR_DEVICE_BYTES: device_ff <= csr_data[SIZE_W-1:0];
            CSR_BASE_OFFSET:  base_ff <= csr_data[ADDR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; first_ff <= 1'b0; result_ff <= RES_OK;
         kind_ff <= KIND_NONE; phase_ff <= PH_MAIN;
         naddr_ff <= '0; left_ff <= '0; done_ff <= '0;
         limit_ff <= '0; bleft_ff <= '0; bbytes_ff <= '0;
      end else if (cmd.commit) begin
         busy_ff <= busy_in; first_ff <= first_in; result_ff <= result_in;
         kind_ff <= kind_in; phase_ff <= phase_in;
         naddr_ff <= naddr_in; left_ff <= left_in; done_ff <= done_in;
         limit_ff <= limit_in; bleft_ff <= bleft_in; bbytes_ff <= bbytes_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) rsp_ff <= rsp_in;
   end

   assign rsp_payload = rsp_ff;

endmodule

>>> sv/spi_eeprom_job_sequencer.sv
// Serial EEPROM job sequencer: each item, whatever its opcode, gives one result item.
// After an item is accepted, the block forms the bit-serial remainder of the job address
// by the page size that caps write chunks, then updates the job state and registers the
// result. The next item is taken only when the block is idle again, so one item is in
// flight at a time. A result waiting on rsp_stall does not block acceptance of the next
// item; that item's update waits only until the output register is free.
module spi_eeprom_job_sequencer #(
   parameter int unsigned COMPARE_BLOCK = 64,
   parameter int unsigned ADDR_BITS     = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  sejs_pkg::req_type               req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output sejs_pkg::rsp_type               rsp_payload,
   input  logic                            csr_write,
   input  logic [sejs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sejs_pkg::CSR_DATA_W-1:0] csr_data
);
   import sejs_pkg::*;

   cmd_type cmd;
   sts_type sts;

   sejs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   sejs_dp #(
      .COMPARE_BLOCK (COMPARE_BLOCK),
      .ADDR_BITS     (ADDR_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .sts         (sts)
   );

`ifndef NO_ASSERTIONS
   a_commit_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid || !rsp_stall))
      else $error("state update while result slot occupied");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second item accepted while one is in flight");

   a_load_only_on_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (req_valid && !req_stall))
      else $error("request latched without handshake");
`endif

endmodule

>>> tb/sejs_checker.sv
`timescale 1ns / 100ps

module sejs_checker
   import sejs_pkg::*;
#(
   parameter int unsigned COMPARE_BLOCK = 64,
   parameter int unsigned ADDR_BITS     = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_type               req_payload,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_type               rsp_payload,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    fail_count,
   output int                    outstanding
);

   localparam int unsigned SIZE_MASK = 32'h1ffff;

   // configuration copy
   logic              m_fast;
   logic [6:0]        m_fast_rd, m_norm_rd, m_fast_wr, m_norm_wr;
   logic [8:0]        m_page;
   logic [16:0]       m_device;
   logic [15:0]       m_base;

   // job state copy
   logic              busy;
   logic [1:0]        res_code, kind, ph;
   logic              first;
   int unsigned       nxt_addr, left_bytes, offset_done;
   int unsigned       chunk_cap, blk_left, blk_bytes;

   rsp_type           expected_rsp[$];

   function automatic int unsigned clamp_blk(logic [6:0] v);
      if (v == 0) return 1;
      if (v > 64) return 64;
      return v;
   endfunction

   function automatic int unsigned min2(int unsigned a, int unsigned b);
      return (a < b) ? a : b;
   endfunction

   function automatic void end_job(logic [1:0] code);
      res_code = code;
      busy     = 1'b0;
      kind     = KIND_NONE;
      ph       = PH_MAIN;
      first    = 1'b0;
   endfunction

   // advances the chunk engine: 0 pending, 1 sub-job done, 2 failed
   function automatic int advance(req_type r, inout rsp_type o);
      int unsigned rem, c, room;
      rem = (kind == KIND_COMPARE) ? blk_left : left_bytes;
      if (first) first = 1'b0;
      else if (r.spi_result == SPI_PENDING) return 0;
      else if (r.spi_result != SPI_OK) return 2;
      if (ph == PH_CHECK) ph = r.status_byte[0] ? PH_STATUS : PH_MAIN;
      if (ph == PH_STATUS) begin
         if (r.spi_accepts) begin
            o.spi_command = CMD_STATUS;
            ph = PH_CHECK;
         end
         return 0;
      end
      ph = PH_MAIN;
      if (rem == 0) return 1;
      c = min2(rem, chunk_cap);
      if (kind == KIND_WRITE && m_page != 0) begin
         room = m_page - (nxt_addr % m_page);
         c = min2(c, room);
      end
      if (!r.spi_accepts) return 0;
      o.spi_command   = (kind == KIND_WRITE) ? CMD_WRITE : CMD_READ;
      o.spi_address   = nxt_addr[ADDR_BITS-1:0];
      o.chunk_bytes   = c[6:0];
      o.buffer_offset = offset_done[16:0];
      nxt_addr    = (nxt_addr + c) & SIZE_MASK;
      offset_done = (offset_done + c) & SIZE_MASK;
      if (kind == KIND_COMPARE) blk_left = rem - c;
      else left_bytes = rem - c;
      ph = PH_STATUS;
      return 0;
   endfunction

   function automatic rsp_type predict_job_step(req_type r);
      rsp_type     o;
      int          rv;
      int unsigned blk;
      o = '0;
      if (r.opcode <= OP_COMPARE) begin
         if (!busy && r.address < m_device && r.length <= m_device - r.address) begin
            busy     = 1'b1;
            res_code = RES_PENDING;
            kind     = (r.opcode == OP_READ) ? KIND_READ :
                       (r.opcode == OP_WRITE) ? KIND_WRITE : KIND_COMPARE;
            if (r.opcode == OP_WRITE) blk = m_fast ? m_fast_wr : m_norm_wr;
            else blk = m_fast ? m_fast_rd : m_norm_rd;
            chunk_cap   = clamp_blk(blk[6:0]);
            first       = 1'b1;
            ph          = PH_MAIN;
            nxt_addr    = (r.address + m_base) & SIZE_MASK;
            left_bytes  = r.length;
            offset_done = 0;
            blk_bytes   = min2(r.length, COMPARE_BLOCK);
            blk_left    = blk_bytes;
            o.accepted  = 1'b1;
         end
      end else if (r.opcode == OP_POLL) begin
         if (res_code == RES_PENDING && busy && kind != KIND_NONE) begin
            rv = advance(r, o);
            if (rv == 2) begin
               end_job(RES_FAILED);
               o.job_error = 1'b1;
            end else if (rv == 1) begin
               if (kind != KIND_COMPARE) begin
                  end_job(RES_OK);
                  o.job_end = 1'b1;
               end else if (blk_bytes != 0 && !r.compare_equal) begin
                  o.compare_check = 1'b1;
                  end_job(RES_FAILED);
                  o.job_error = 1'b1;
               end else begin
                  o.compare_check = (blk_bytes != 0);
                  left_bytes = left_bytes - blk_bytes;
                  if (left_bytes == 0) begin
                     end_job(RES_OK);
                     o.job_end = 1'b1;
                  end else begin
                     blk_bytes = min2(left_bytes, COMPARE_BLOCK);
                     blk_left  = blk_bytes;
                     first     = 1'b1;
                     ph        = PH_MAIN;
                  end
               end
            end
         end
      end else if (r.opcode == OP_CANCEL) begin
         o.job_error = 1'b1;
         end_job((res_code == RES_PENDING) ? RES_CANCELLED : res_code);
      end
      o.driver_busy = busy;
      o.job_result  = res_code;
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         m_fast = 0; m_fast_rd = 64; m_norm_rd = 32; m_fast_wr = 32; m_norm_wr = 16;
         m_page = 16; m_device = 2048; m_base = 0;
         busy = 0; res_code = RES_OK; kind = KIND_NONE; ph = PH_MAIN; first = 0;
         nxt_addr = 0; left_bytes = 0; offset_done = 0;
         chunk_cap = 0; blk_left = 0; blk_bytes = 0;
         expected_rsp.delete();
         fail_count <= 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_FAST_MODE:    m_fast    = csr_data[0];
               CSR_FAST_READ:    m_fast_rd = csr_data[6:0];
               CSR_NORMAL_READ:  m_norm_rd = csr_data[6:0];
               CSR_FAST_WRITE:   m_fast_wr = csr_data[6:0];
               CSR_NORMAL_WRITE: m_norm_wr = csr_data[6:0];
               CSR_PAGE_BYTES:   m_page    = csr_data[8:0];
               CSR_DEVICE_BYTES: m_device  = csr_data[16:0];
               CSR_BASE_OFFSET:  m_base    = csr_data[15:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) expected_rsp.push_back(predict_job_step(req_payload));
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               if (fail_count < 10) $display("unexpected item: %p", rsp_payload);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_payload !== want) begin
                  if (fail_count < 10)
                     $display("mismatch: expected %p actual %p", want, rsp_payload);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      outstanding <= expected_rsp.size();
   end

endmodule

>>> tb/tb_spi_eeprom_job_sequencer.sv
`timescale 1ns / 100ps

module tb_spi_eeprom_job_sequencer;
   import sejs_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_payload;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   int                    fail_count;
   int                    outstanding;
   int                    idle_pct = 0;
   int                    stall_pct = 0;
   int unsigned           dev_size = 2048;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   spi_eeprom_job_sequencer i_dut (
      .clock, .reset, .req_valid, .req_stall, .req_payload,
      .rsp_valid, .rsp_stall, .rsp_payload, .csr_write, .csr_index, .csr_data
   );

   sejs_checker i_checker (
      .clock, .reset, .req_valid, .req_stall, .req_payload,
      .rsp_valid, .rsp_stall, .rsp_payload, .csr_write, .csr_index, .csr_data,
      .fail_count, .outstanding
   );

   always @(posedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   initial begin
      #20_000_000;
      $display("FAIL");
      $finish;
   end

   function automatic req_type make_item(logic [2:0] op, int unsigned addr, int unsigned len,
                                         logic [1:0] spi_r, logic acc, logic [7:0] st,
                                         logic eq);
      req_type r;
      r.opcode        = op;
      r.address       = addr[15:0];
      r.length        = len[16:0];
      r.spi_result    = spi_r;
      r.spi_accepts   = acc;
      r.status_byte   = st;
      r.compare_equal = eq;
      return r;
   endfunction

   // called at a rising edge, returns at the edge where the item is taken
   task automatic send_item(req_type r);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0 || req_valid) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   // leaves csr_write high; the caller drops it after the last write
   task automatic write_reg(logic [2:0] idx, int unsigned val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val[16:0];
      @(posedge clock);
      if (idx == CSR_DEVICE_BYTES) dev_size = val & 32'h1ffff;
   endtask

   function automatic req_type random_poll();
      logic [1:0] r;
      int unsigned p;
      p = $urandom_range(99);
      r = (p < 80) ? SPI_OK : (p < 90) ? SPI_PENDING : 2'($urandom_range(2, 3));
      return make_item(OP_POLL, $urandom, $urandom, r, $urandom_range(99) < 85,
                       8'($urandom_range(255)) & 8'hfe | 8'($urandom_range(99) < 30),
                       $urandom_range(99) < 95);
   endfunction

   task automatic random_run(int count);
      int n;
      int unsigned addr, len, room, polls;
      n = 0;
      while (n < count) begin
         if ($urandom_range(99) < 85) begin
            addr = (dev_size == 0) ? $urandom_range(65535)
                 : $urandom_range((dev_size > 65536 ? 65536 : dev_size) - 1);
            room = (dev_size > addr) ? dev_size - addr : 0;
            len  = $urandom_range(room < 80 ? room : 80);
            if ($urandom_range(99) < 4) len = room;
            if ($urandom_range(99) < 5) len = room + 1;
            send_item(make_item(3'($urandom_range(2)), addr, len, 2'($urandom),
                                1'($urandom), 8'($urandom), 1'($urandom)));
            polls = $urandom_range(1, 50);
            for (int i = 0; i < polls; i++) send_item(random_poll());
            n += polls + 1;
            if ($urandom_range(99) < 50) begin
               send_item(make_item(OP_CANCEL, $urandom, $urandom, 2'($urandom),
                                   1'($urandom), 8'($urandom), 1'($urandom)));
               n++;
            end
         end else begin
            send_item(make_item(3'($urandom_range(7)), $urandom, $urandom, 2'($urandom),
                                1'($urandom), 8'($urandom), 1'($urandom)));
            n++;
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero length, edges of the device, refused commands, failures
      send_item(make_item(OP_READ, 0, 0, SPI_OK, 1, 0, 1));
      send_item(make_item(OP_POLL, 0, 0, SPI_PENDING, 1, 0, 1));
      send_item(make_item(OP_COMPARE, 2047, 1, SPI_OK, 1, 0, 1));
      send_item(make_item(OP_WRITE, 0, 1, SPI_OK, 1, 0, 1));
      send_item(make_item(OP_POLL, 0, 0, SPI_PENDING, 0, 0, 1));
      send_item(make_item(OP_POLL, 0, 0, SPI_PENDING, 1, 0, 1));
      send_item(make_item(OP_POLL, 0, 0, SPI_PENDING, 1, 0, 1));
      send_item(make_item(OP_POLL, 0, 0, SPI_OK, 1, 8'hff, 1));
      send_item(make_item(OP_POLL, 0, 0, SPI_OK, 1, 8'hff, 1));
      send_item(make_item(OP_POLL, 0, 0, SPI_OK, 1, 8'h00, 0));
      send_item(make_item(OP_POLL, 0, 0, SPI_OK, 1, 8'h00, 0));
      send_item(make_item(OP_POLL, 0, 0, SPI_OK, 1, 8'h00, 0));
      send_item(make_item(OP_POLL, 0, 0, 2'd2, 1, 0, 0));
      send_item(make_item(OP_WRITE, 2040, 8, SPI_OK, 1, 0, 1));
      send_item(make_item(OP_POLL, 0, 0, SPI_OK, 1, 0, 1));
      send_item(make_item(OP_POLL, 0, 0, 2'd3, 1, 0, 1));
      send_item(make_item(OP_READ, 2048, 0, SPI_OK, 1, 0, 1));
      send_item(make_item(OP_READ, 65535, 17'h1ffff, 2'd3, 1, 8'hff, 1));
      send_item(make_item(OP_READ, 0, 2049, SPI_OK, 1, 0, 1));
      send_item(make_item(OP_READ, 0, 2048, SPI_OK, 1, 0, 1));
      send_item(make_item(OP_COMPARE, 0, 4, SPI_OK, 1, 0, 1));
      send_item(make_item(OP_CANCEL, 0, 0, SPI_OK, 1, 0, 1));
      send_item(make_item(OP_CANCEL, 0, 0, SPI_OK, 1, 0, 1));
      send_item(make_item(3'd5, 0, 0, SPI_OK, 1, 0, 1));
      send_item(make_item(3'd7, 16'hffff, 17'h1ffff, 2'd3, 1, 8'hff, 1));

      for (int ph = 0; ph < 8; ph++) begin
         settle();
         case (ph)
            0: ;
            1: begin
               write_reg(CSR_FAST_MODE, 1); write_reg(CSR_FAST_READ, 1);
               write_reg(CSR_FAST_WRITE, 64); write_reg(CSR_PAGE_BYTES, 0);
            end
            2: begin
               write_reg(CSR_FAST_MODE, 0); write_reg(CSR_NORMAL_READ, 0);
               write_reg(CSR_NORMAL_WRITE, 127); write_reg(CSR_PAGE_BYTES, 1);
               write_reg(CSR_BASE_OFFSET, 65535);
            end
            3: begin
               write_reg(CSR_NORMAL_READ, 64); write_reg(CSR_NORMAL_WRITE, 1);
               write_reg(CSR_PAGE_BYTES, 256); write_reg(CSR_DEVICE_BYTES, 65536);
               write_reg(CSR_BASE_OFFSET, 40000);
            end
            4: begin
               write_reg(CSR_FAST_MODE, 1); write_reg(CSR_FAST_READ, 127);
               write_reg(CSR_FAST_WRITE, 0); write_reg(CSR_PAGE_BYTES, 511);
               write_reg(CSR_DEVICE_BYTES, 1);
            end
            5: begin
               write_reg(CSR_DEVICE_BYTES, 0); write_reg(CSR_BASE_OFFSET, 0);
            end
            6: begin
               write_reg(CSR_FAST_READ, 37); write_reg(CSR_FAST_WRITE, 13);
               write_reg(CSR_PAGE_BYTES, 24); write_reg(CSR_DEVICE_BYTES, 131071);
               write_reg(CSR_BASE_OFFSET, 65530);
            end
            default: begin
               write_reg(CSR_FAST_MODE, 0); write_reg(CSR_NORMAL_READ, 7);
               write_reg(CSR_NORMAL_WRITE, 5); write_reg(CSR_PAGE_BYTES, 8);
               write_reg(CSR_DEVICE_BYTES, 300);
            end
         endcase
         csr_write <= 1'b0;
         idle_pct  = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 3) ? 32 : 59) : 0;
         stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? ((ph % 4 == 3) ? 32 : 59) : 0;
         random_run(235);
      end

      settle();
      repeat (40) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
